### rtl/core/bsfd_pkg.sv
package bsfd_pkg;

    // default sizing of the delay store
    localparam int DEF_MAX_DELAY_FRAMES = 400;
    localparam int DEF_MAX_FRAME_PIXELS = 256;

    // field widths
    localparam int PIX_W      = 32;
    localparam int FP_W       = 9;
    localparam int AMT_W      = 8;
    localparam int DELAY_W    = 9;
    localparam int MULT_W     = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // delay limits
    localparam int FSB_SAT       = 400;
    localparam int BEAT_CAP      = 400;
    localparam int BEAT_MULT_MAX = 16;
    localparam int FRAMES_MAX    = 200;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_MODE    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_AMOUNT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = CFG_IDX_W'(3);

    // register reset values
    localparam logic             RST_ENABLE       = 1'b1;
    localparam logic             RST_BEAT_MODE    = 1'b0;
    localparam logic [AMT_W-1:0] RST_DELAY_AMOUNT = AMT_W'(10);
    localparam logic [FP_W-1:0]  RST_FRAME_PIXELS = FP_W'(256);

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             beat;
        logic             skip_frame;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             delayed;
    } t_pix_out;

    // limit the stored delay amount to what the mode allows
    function automatic logic [AMT_W-1:0] clamp_amount(input logic [AMT_W-1:0] amount,
                                                      input logic beat_mode);
        logic [AMT_W-1:0] lim;
        lim = beat_mode ? AMT_W'(BEAT_MULT_MAX) : AMT_W'(FRAMES_MAX);
        return (amount > lim) ? lim : amount;
    endfunction

endpackage

### rtl/core/bsfd_ring_store.sv
module bsfd_ring_store #(
    parameter int DEPTH = bsfd_pkg::DEF_MAX_DELAY_FRAMES * bsfd_pkg::DEF_MAX_FRAME_PIXELS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  logic [ADDR_W-1:0]          i_addr,
    input  logic [bsfd_pkg::PIX_W-1:0] i_wdata,
    output logic [bsfd_pkg::PIX_W-1:0] o_rdata,
    output logic                       o_busy
);
    import bsfd_pkg::*;

    logic [PIX_W-1:0]  r_mem [DEPTH];
    logic [PIX_W-1:0]  r_rdata;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_busy;

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // read-first port: old word out, new word in
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_acc) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

### rtl/core/beat_synced_frame_delay_core.sv
// frame delay line for a raster pixel stream, one pixel per clock sustained while the
// output is taken and no register write is pending. each accepted, delayed pixel does
// one read-modify-write of the delay store at slot*frame+offset, the old word going
// out and the new pixel going in at the same edge, so back to back pixels never wait
// on each other. a result goes via stage one to the output register; one more request
// is taken while a result waits downstream. after reset the store is swept to zero,
// one word a cycle, over all MAX_DELAY_FRAMES * MAX_FRAME_PIXELS words (102400 at the
// defaults), during which no pixel is accepted; register writes are always taken, and
// a write holds off the pixel input for that cycle. the delay is picked at the first
// pixel of every unskipped frame, from the fixed count or the beat counter.
module beat_synced_frame_delay_core #(
    parameter int MAX_DELAY_FRAMES = bsfd_pkg::DEF_MAX_DELAY_FRAMES,
    parameter int MAX_FRAME_PIXELS = bsfd_pkg::DEF_MAX_FRAME_PIXELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bsfd_pkg::t_pix_in               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bsfd_pkg::t_pix_out              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bsfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bsfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bsfd_pkg::*;

    localparam int DEPTH  = MAX_DELAY_FRAMES * MAX_FRAME_PIXELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = (MAX_DELAY_FRAMES > 1) ? $clog2(MAX_DELAY_FRAMES) : 1;
    localparam int OFF_W  = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
    localparam int LEN_W  = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int CMP_W  = ((LEN_W > FP_W) ? LEN_W : FP_W) + 1;
    localparam int PROD_W = DELAY_W + MULT_W;

    // configuration
    logic             r_enable;
    logic             r_beat_mode;
    logic [AMT_W-1:0] r_delay_amount;
    logic [FP_W-1:0]  r_frame_pixels;

    // frame sequencing state
    logic [OFF_W-1:0]   r_offset,    n_offset;
    logic [SLOT_W-1:0]  r_slot,      n_slot;
    logic [ADDR_W-1:0]  r_slot_base, n_slot_base;
    logic [DELAY_W-1:0] r_cur,       n_cur;
    logic [DELAY_W-1:0] r_applied,   n_applied;
    logic [DELAY_W-1:0] r_fsb,       n_fsb;
    logic               r_bypass,    n_bypass;
    logic               r_engaged,   n_engaged;

    // pipeline: stage one waits on the store read, then the output register
    logic             r_s1_valid;
    logic             r_s1_delayed;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_out_valid;
    t_pix_out         r_out_data;

    logic              n_active;
    logic [ADDR_W-1:0] n_addr;
    logic              in_accept;
    logic              s1_move;
    logic              store_busy;
    logic [PIX_W-1:0]  store_rdata;
    logic              cfg_accept;

    logic [CMP_W-1:0]   len_c;
    logic [CMP_W-1:0]   fp_ext;
    logic [MULT_W-1:0]  mult;
    logic [PROD_W-1:0]  prod;
    logic [DELAY_W-1:0] amt_frames;
    logic               frame_start;
    logic               frame_end;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    // a register write takes the state update slot, so no pixel enters with it
    assign o_in_ready = !store_busy && !i_cfg_valid && (!r_s1_valid || s1_move);
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_accept = i_cfg_valid;

    // frame length: zero counts as one, long frames clamp to the store row
    assign fp_ext = CMP_W'(r_frame_pixels);
    always_comb begin
        if (r_frame_pixels == '0) begin
            len_c = CMP_W'(1);
        end else if (fp_ext > CMP_W'(MAX_FRAME_PIXELS)) begin
            len_c = CMP_W'(MAX_FRAME_PIXELS);
        end else begin
            len_c = fp_ext;
        end
    end

    // beat product, multiplier clamped to sixteen
    assign mult = (r_delay_amount > AMT_W'(BEAT_MULT_MAX)) ? MULT_W'(BEAT_MULT_MAX)
                                                           : r_delay_amount[MULT_W-1:0];
    assign prod = PROD_W'(r_fsb) * PROD_W'(mult);
    assign amt_frames = (r_delay_amount > AMT_W'(FRAMES_MAX)) ? DELAY_W'(FRAMES_MAX)
                                                              : DELAY_W'(r_delay_amount);

    assign frame_start = (r_offset == '0);
    assign frame_end   = (CMP_W'(r_offset) + CMP_W'(1)) >= len_c;

    // per-pixel sequencing: frame start decisions, then slot advance at frame end
    always_comb begin
        n_offset    = r_offset;
        n_slot      = r_slot;
        n_slot_base = r_slot_base;
        n_cur       = r_cur;
        n_applied   = r_applied;
        n_fsb       = r_fsb;
        n_bypass    = r_bypass;
        n_engaged   = r_engaged;

        if (frame_start) begin
            n_bypass = i_in_data.skip_frame;
            if (!i_in_data.skip_frame) begin
                if (r_beat_mode) begin
                    if (i_in_data.beat) begin
                        n_cur = (prod > PROD_W'(BEAT_CAP)) ? DELAY_W'(BEAT_CAP)
                                                           : DELAY_W'(prod);
                        n_fsb = '0;
                    end
                    if (n_fsb < DELAY_W'(FSB_SAT)) begin
                        n_fsb = n_fsb + 1'b1;
                    end
                end else begin
                    n_cur = amt_frames;
                end
                if (n_cur > DELAY_W'(MAX_DELAY_FRAMES)) begin
                    n_cur = DELAY_W'(MAX_DELAY_FRAMES);
                end
                n_engaged = r_enable && (n_cur != '0);
                // delay change: fall back to slot zero if the slot is now out of range
                if (n_engaged && (n_cur != r_applied)) begin
                    if (DELAY_W'(r_slot) >= n_cur) begin
                        n_slot      = '0;
                        n_slot_base = '0;
                    end
                    n_applied = n_cur;
                end
            end
        end

        n_active = !n_bypass && n_engaged;
        n_addr   = n_slot_base + ADDR_W'(r_offset);

        if (frame_end) begin
            n_offset = '0;
            if (n_active) begin
                if ((DELAY_W'(n_slot) + DELAY_W'(1)) >= n_applied) begin
                    n_slot      = '0;
                    n_slot_base = '0;
                end else begin
                    n_slot      = n_slot + 1'b1;
                    n_slot_base = n_slot_base + ADDR_W'(MAX_FRAME_PIXELS);
                end
            end
        end else begin
            n_offset = r_offset + 1'b1;
        end
    end

    // configuration and sequencing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= RST_ENABLE;
            r_beat_mode    <= RST_BEAT_MODE;
            r_delay_amount <= RST_DELAY_AMOUNT;
            r_frame_pixels <= RST_FRAME_PIXELS;
            r_offset       <= '0;
            r_slot         <= '0;
            r_slot_base    <= '0;
            r_cur          <= '0;
            r_applied      <= '0;
            r_fsb          <= '0;
            r_bypass       <= 1'b0;
            r_engaged      <= 1'b0;
        end else if (cfg_accept) begin
            unique case (i_cfg_index)
                REG_ENABLE: begin
                    r_enable <= i_cfg_data[0];
                end
                REG_BEAT_MODE: begin
                    // mode change reclamps the amount and restarts the delay
                    r_beat_mode    <= i_cfg_data[0];
                    r_delay_amount <= clamp_amount(r_delay_amount, i_cfg_data[0]);
                    r_cur          <= '0;
                    r_fsb          <= '0;
                end
                REG_DELAY_AMOUNT: begin
                    r_delay_amount <= clamp_amount(i_cfg_data[AMT_W-1:0], r_beat_mode);
                    r_cur          <= '0;
                    r_fsb          <= '0;
                end
                REG_FRAME_PIXELS: begin
                    r_frame_pixels <= i_cfg_data[FP_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (in_accept) begin
            r_offset    <= n_offset;
            r_slot      <= n_slot;
            r_slot_base <= n_slot_base;
            r_cur       <= n_cur;
            r_applied   <= n_applied;
            r_fsb       <= n_fsb;
            r_bypass    <= n_bypass;
            r_engaged   <= n_engaged;
        end
    end

    // delay store, one read-modify-write per delayed pixel
    bsfd_ring_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_accept && n_active),
        .i_addr  (n_addr),
        .i_wdata (i_in_data.pixel_in),
        .o_rdata (store_rdata),
        .o_busy  (store_busy)
    );

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pix     <= i_in_data.pixel_in;
            r_s1_delayed <= n_active;
        end
        if (s1_move) begin
            r_out_data.pixel_out <= r_s1_delayed ? store_rdata : r_s1_pix;
            r_out_data.delayed   <= r_s1_delayed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // an engaged frame always sits on a slot inside the applied delay
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_engaged && !r_bypass) |-> (DELAY_W'(r_slot) < r_applied))
        else $error("slot index outside applied delay");

    // slot base tracks slot index times the row length
    a_base_matches_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_base == ADDR_W'(ADDR_W'(r_slot) * ADDR_W'(MAX_FRAME_PIXELS)))
        else $error("slot base out of step with slot index");

    // no pixel enters while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_busy |-> !in_accept)
        else $error("pixel accepted during store clear");

    // an accepted pixel always lands in stage one
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted pixel lost before stage one");

endmodule

### tb/sv/beat_synced_frame_delay_core_tb.sv
`timescale 1ns / 1ps

module beat_synced_frame_delay_core_tb;
    import bsfd_pkg::*;

    // sizing of the delay store as the block is built here
    localparam int STORE_FRAMES = DEF_MAX_DELAY_FRAMES;
    localparam int STORE_PIXELS = DEF_MAX_FRAME_PIXELS;

    // cycles for a result to clear the pipe before a register write
    localparam int SETTLE_CYCLES = 4;
    // receiver hold-off long enough to back the block up to its input
    localparam int LONG_HOLD = 40;
    // covers the store sweep after reset plus every request at its slowest
    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_pix_in               i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_pix_out              o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    beat_synced_frame_delay_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // predictor state: registers, frame tracking and the delay store
    // ---------------------------------------------------------------
    logic             cfg_enable;
    logic             cfg_beat_mode;
    logic [AMT_W-1:0] cfg_amount;
    logic [FP_W-1:0]  cfg_frame_pix;

    logic [DELAY_W-1:0] slot_idx;
    logic [8:0]         pix_off;
    logic [DELAY_W-1:0] cur_delay;
    logic [DELAY_W-1:0] appl_delay;
    logic [8:0]         frames_since_beat;
    logic               frame_skipped;
    logic               frame_delayed;

    // words never written read back as zero, the store is swept at reset
    logic [PIX_W-1:0] delay_store_model [int];

    t_pix_out expected_pixels [$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  gaps_on     = 1'b1;
    bit  stalls_on   = 1'b1;
    int  hold_req    = 0;
    int  hold_seen   = 0;
    int  rx_hold     = 0;

    // register write as the block sees it: mode and amount writes re-clamp
    // the amount and restart the delay and the beat counter
    task automatic model_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        bit restart;
        restart = 1'b0;
        case (idx)
            REG_ENABLE:       cfg_enable = data[0];
            REG_BEAT_MODE: begin
                cfg_beat_mode = data[0];
                restart = 1'b1;
            end
            REG_DELAY_AMOUNT: begin
                cfg_amount = data[AMT_W-1:0];
                restart = 1'b1;
            end
            REG_FRAME_PIXELS: cfg_frame_pix = data[FP_W-1:0];
            default: ;
        endcase
        if (restart) begin
            if (cfg_beat_mode && cfg_amount > BEAT_MULT_MAX)
                cfg_amount = AMT_W'(BEAT_MULT_MAX);
            else if (!cfg_beat_mode && cfg_amount > FRAMES_MAX)
                cfg_amount = AMT_W'(FRAMES_MAX);
            cur_delay = '0;
            frames_since_beat = '0;
        end
    endtask

    // delay choice at the first pixel of a frame that is not skipped
    task automatic model_frame_start(input logic beat);
        int mult;
        int span;
        mult = cfg_amount;
        if (cfg_beat_mode) begin
            if (beat) begin
                if (mult > BEAT_MULT_MAX) mult = BEAT_MULT_MAX;
                span = frames_since_beat * mult;
                if (span > BEAT_CAP) span = BEAT_CAP;
                cur_delay = DELAY_W'(span);
                frames_since_beat = '0;
            end
            if (frames_since_beat < FSB_SAT) frames_since_beat = frames_since_beat + 1'b1;
        end else begin
            if (mult > FRAMES_MAX) mult = FRAMES_MAX;
            cur_delay = DELAY_W'(mult);
        end
        if (cur_delay > STORE_FRAMES) cur_delay = DELAY_W'(STORE_FRAMES);
        frame_delayed = cfg_enable && (cur_delay != 0);
        // a changed delay pulls the slot back inside the ring
        if (frame_delayed && cur_delay != appl_delay) begin
            if (slot_idx >= cur_delay) slot_idx = '0;
            appl_delay = cur_delay;
        end
    endtask

    // expected result for one accepted pixel, updating the predictor state
    task automatic predict_pixel(input t_pix_in req, output t_pix_out res);
        int len;
        int slot;
        int addr;
        bit hit;
        len = cfg_frame_pix;
        if (len == 0) len = 1;
        if (len > STORE_PIXELS) len = STORE_PIXELS;
        if (pix_off >= STORE_PIXELS) pix_off = '0;
        if (pix_off == 0) begin
            frame_skipped = req.skip_frame;
            if (!req.skip_frame) model_frame_start(req.beat);
        end
        hit = !frame_skipped && frame_delayed;
        if (hit) begin
            slot = (slot_idx >= STORE_FRAMES) ? 0 : int'(slot_idx);
            addr = slot * STORE_PIXELS + int'(pix_off);
            res.pixel_out = delay_store_model.exists(addr) ? delay_store_model[addr] : '0;
            res.delayed   = 1'b1;
            delay_store_model[addr] = req.pixel_in;
        end else begin
            res.pixel_out = req.pixel_in;
            res.delayed   = 1'b0;
        end
        // end of frame as soon as the offset reaches the length in force now
        if (int'(pix_off) + 1 >= len) begin
            pix_off = '0;
            if (hit) begin
                slot_idx = slot_idx + 1'b1;
                if (slot_idx >= appl_delay) slot_idx = '0;
            end
        end else begin
            pix_off = pix_off + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch on %s: got %h want %h", what, got, want);
    endtask

    // ---------------------------------------------------------------
    // result side: random stalls, long hold-offs, and the checker
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            rx_hold   = LONG_HOLD;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            // hold-off burst that starts with this one and runs on for a random length
            rx_hold = $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result", o_out_data.pixel_out, '0);
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_data.pixel_out !== want.pixel_out)
                    report_mismatch("pixel_out", o_out_data.pixel_out, want.pixel_out);
                if (o_out_data.delayed !== want.delayed)
                    report_mismatch("delayed", 32'(o_out_data.delayed), 32'(want.delayed));
            end
        end
    end

    // hard stop if anything hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // offer one pixel, keeping valid up from the previous request unless a gap falls
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic beat,
                              input logic skip);
        t_pix_in  req;
        t_pix_out want;
        req.pixel_in   = pix;
        req.beat       = beat;
        req.skip_frame = skip;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_data  <= req;
        i_in_valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predict_pixel(req, want);
        expected_pixels.push_back(want);
        @(negedge i_clk);
    endtask

    // random content, beats made rarer in beat mode so delays build up
    task automatic send_random_pixel();
        logic beat;
        beat = cfg_beat_mode ? ($urandom_range(0, 2) == 0) : 1'($urandom_range(0, 1));
        send_pixel($urandom, beat, $urandom_range(0, 7) == 0);
    endtask

    // stop offering and wait until every result is back and the pipe is quiet
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register writes only go out with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_pipeline();
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        model_reg_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // each register rewritten at random, upper data bits as noise
    task automatic pick_settings();
        logic [31:0]      noise;
        logic [AMT_W-1:0] amt;
        logic [FP_W-1:0]  fp;
        noise = $urandom;
        if ($urandom_range(0, 1))
            write_reg(REG_ENABLE, {noise[31:1], 1'($urandom_range(0, 3) != 0)});
        if ($urandom_range(0, 1))
            write_reg(REG_BEAT_MODE, {noise[31:1], 1'($urandom_range(0, 1))});
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 4))
                0:       amt = '0;
                1:       amt = '1;
                2:       amt = AMT_W'($urandom_range(1, 8));
                3:       amt = AMT_W'($urandom_range(14, 20));
                default: amt = AMT_W'($urandom);
            endcase
            write_reg(REG_DELAY_AMOUNT, {noise[31:AMT_W], amt});
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
                0:       fp = '0;
                1:       fp = '1;
                default: fp = FP_W'($urandom_range(1, 6));
            endcase
            write_reg(REG_FRAME_PIXELS, {noise[31:FP_W], fp});
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset values, field extremes and each corner of the frame logic
    task automatic test_directed_cases();
        // long default frame that starts skipped; skip and beat ignored mid-frame
        send_pixel(32'h8000_0000, 1'b1, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_pixel(32'h0000_0000, 1'b0, 1'b1);
        // zero length reads as one pixel, cutting the current frame short
        write_reg(REG_FRAME_PIXELS, 32'hFFFF_FE00);
        send_pixel(32'h1234_5678, 1'b0, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_pixel(32'h0000_0000, 1'b1, 1'b0);
        // oversized amount clamps to the frames-mode maximum
        write_reg(REG_DELAY_AMOUNT, 32'hFFFF_FFFF);
        send_pixel(32'h8000_0000, 1'b0, 1'b0);
        send_pixel(32'h7FFF_FFFF, 1'b0, 1'b0);
        // shrink to one frame: slot falls back to zero
        write_reg(REG_DELAY_AMOUNT, 32'd1);
        send_pixel(32'hA5A5_0001, 1'b0, 1'b0);
        send_pixel(32'h5A5A_0002, 1'b0, 1'b0);
        send_pixel(32'hC3C3_0003, 1'b0, 1'b1);
        // disabled: straight pass-through
        write_reg(REG_ENABLE, 32'h0);
        send_pixel(32'h0F0F_0004, 1'b1, 1'b0);
        send_pixel(32'hF0F0_0005, 1'b0, 1'b0);
        write_reg(REG_ENABLE, 32'hFFFF_FFFF);
        // beat mode: beat on a zeroed counter gives no delay
        write_reg(REG_BEAT_MODE, 32'h1);
        send_pixel(32'h1111_0006, 1'b1, 1'b0);
        send_pixel(32'h2222_0007, 1'b0, 1'b0);
        send_pixel(32'h3333_0008, 1'b1, 1'b0);
        send_pixel(32'h4444_0009, 1'b0, 1'b0);
        // indexes past the register map change nothing
        write_reg(CFG_IDX_W'(4), $urandom);
        write_reg('1, $urandom);
        send_pixel(32'h5555_000A, 1'b1, 1'b0);
        // length above the store width counts as the full width
        write_reg(REG_FRAME_PIXELS, 32'h0000_01FF);
        send_pixel(32'h6666_000B, 1'b0, 1'b0);
        write_reg(REG_BEAT_MODE, 32'h0);
    endtask

    // beat counter runs into saturation, then a beat hits the delay cap
    task automatic test_beat_counter_saturation();
        write_reg(REG_FRAME_PIXELS, 32'hDEAD_BE01);
        write_reg(REG_BEAT_MODE, 32'h1);
        write_reg(REG_DELAY_AMOUNT, 32'h0000_00FF);
        for (int k = 0; k < FSB_SAT + 2; k++) send_pixel($urandom, 1'b0, 1'b0);
        send_pixel($urandom, 1'b1, 1'b0);
        for (int k = 0; k < 3; k++) send_pixel($urandom, 1'b0, 1'b0);
        send_pixel($urandom, 1'b1, 1'b0);
        for (int k = 0; k < 3; k++) send_pixel($urandom, 1'b0, $urandom_range(0, 1));
    endtask

    // full-width frames with a one-frame delay: second frame reads back the first
    task automatic test_full_frame();
        write_reg(REG_BEAT_MODE, 32'h0);
        write_reg(REG_DELAY_AMOUNT, 32'h1);
        write_reg(REG_FRAME_PIXELS, 32'(STORE_PIXELS));
        for (int k = 0; k < STORE_PIXELS + 6; k++)
            send_pixel($urandom, 1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0);
    endtask

    // random settings per phase, with a receiver hold-off and a sender pause
    task automatic test_random_settings();
        int n;
        for (int phase = 0; phase < 8; phase++) begin
            pick_settings();
            n = $urandom_range(40, 60);
            for (int k = 0; k < n; k++) begin
                // receiver stops while the sender keeps offering
                if (phase == 2 && k == 10) hold_req++;
                // sender waits for every result mid-stream
                if (phase == 5 && k == 25) drain_pipeline();
                send_random_pixel();
            end
        end
    endtask

    // no idling on either side at the end
    task automatic test_back_to_back();
        write_reg(REG_ENABLE, 32'h1);
        write_reg(REG_BEAT_MODE, 32'h0);
        write_reg(REG_DELAY_AMOUNT, 32'd3);
        write_reg(REG_FRAME_PIXELS, 32'd2);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        for (int k = 0; k < 80; k++) send_random_pixel();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        cfg_enable        = RST_ENABLE;
        cfg_beat_mode     = RST_BEAT_MODE;
        cfg_amount        = RST_DELAY_AMOUNT;
        cfg_frame_pix     = RST_FRAME_PIXELS;
        slot_idx          = '0;
        pix_off           = '0;
        cur_delay         = '0;
        appl_delay        = '0;
        frames_since_beat = '0;
        frame_skipped     = 1'b0;
        frame_delayed     = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first request waits out the store sweep
        test_directed_cases();
        test_beat_counter_saturation();
        test_full_frame();
        test_random_settings();
        test_back_to_back();

        drain_pipeline();
        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/bsfd_pkg.sv
rtl/core/bsfd_ring_store.sv
rtl/core/beat_synced_frame_delay_core.sv
tb/sv/beat_synced_frame_delay_core_tb.sv
